### rtl/pqsl_pkg.sv
// Shared types and codes for the sorted-list priority queue.
`timescale 1ns / 1ps
`default_nettype none

package pqsl_pkg;

  localparam int unsigned PRIO_W = 16;
  localparam int unsigned TAG_W  = 16;
  localparam int unsigned WORD_W = PRIO_W + TAG_W;

  // Operation codes on func_i
  localparam logic [1:0] FUNC_INSERT = 2'd0;
  localparam logic [1:0] FUNC_REMOVE = 2'd1;
  localparam logic [1:0] FUNC_PEEK   = 2'd2;

  // Status codes on status_o
  localparam logic [1:0] STATUS_OK    = 2'd0;
  localparam logic [1:0] STATUS_EMPTY = 2'd1;
  localparam logic [1:0] STATUS_FULL  = 2'd2;

  typedef enum logic [2:0] {
    S_IDLE,
    S_INS_RD,
    S_INS_CMP,
    S_FRONT,
    S_RESP
  } state_e;

  // Kind of result loaded into the output register
  typedef enum logic [1:0] {
    RES_OK,
    RES_EMPTY,
    RES_FULL,
    RES_TAG
  } res_e;

  // Read address select
  typedef enum logic {
    RD_FRONT,
    RD_IDX_M1
  } rd_sel_e;

  // Write data select
  typedef enum logic {
    WR_NEW,
    WR_RDATA
  } wr_sel_e;

  typedef struct packed {
    logic    capture;
    rd_sel_e rd_sel;
    logic    wr_en;
    wr_sel_e wr_sel;
    logic    idx_dec;
    logic    occ_inc;
    logic    pop;
    logic    out_load;
    res_e    out_kind;
  } cmd_t;

  typedef struct packed {
    logic occ_zero;
    logic occ_full;
    logic idx_zero;
    logic stop;
    logic out_free;
  } sts_t;

endpackage

`default_nettype wire

### rtl/pqsl_ctrl.sv
// Controller state machine for the sorted-list priority queue.
`timescale 1ns / 1ps
`default_nettype none

module pqsl_ctrl
  import pqsl_pkg::*;
(
  input  wire logic       clk_i,
  input  wire logic       rst_ni,
  input  wire logic       req_valid_i,
  output logic            req_stall_o,
  input  wire logic [1:0] func_i,
  input  wire sts_t       sts_i,
  output cmd_t            cmd_o
);

  state_e state_q, state_d;
  logic   pop_q, pop_d;
  res_e   res_q, res_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      pop_q   <= 1'b0;
      res_q   <= RES_OK;
    end else begin
      state_q <= state_d;
      pop_q   <= pop_d;
      res_q   <= res_d;
    end
  end

  always_comb begin
    state_d        = state_q;
    pop_d          = pop_q;
    res_d          = res_q;
    req_stall_o    = (state_q != S_IDLE);
    cmd_o          = '0;
    cmd_o.rd_sel   = RD_FRONT;
    cmd_o.wr_sel   = WR_NEW;
    cmd_o.out_kind = RES_OK;

    case (state_q)
      S_IDLE: begin
        if (req_valid_i) begin
          cmd_o.capture = 1'b1;
          case (func_i)
            FUNC_INSERT: begin
              if (sts_i.occ_full) begin
                res_d   = RES_FULL;
                state_d = S_RESP;
              end else begin
                state_d = S_INS_RD;
              end
            end
            FUNC_REMOVE, FUNC_PEEK: begin
              if (sts_i.occ_zero) begin
                res_d   = RES_EMPTY;
                state_d = S_RESP;
              end else begin
                pop_d   = (func_i == FUNC_REMOVE);
                state_d = S_FRONT;
              end
            end
            default: begin
              res_d   = RES_OK;
              state_d = S_RESP;
            end
          endcase
        end
      end

      S_INS_RD: begin
        if (sts_i.idx_zero) begin
          cmd_o.wr_en   = 1'b1;
          cmd_o.occ_inc = 1'b1;
          res_d         = RES_OK;
          state_d       = S_RESP;
        end else begin
          cmd_o.rd_sel = RD_IDX_M1;
          state_d      = S_INS_CMP;
        end
      end

      S_INS_CMP: begin
        cmd_o.wr_en = 1'b1;
        if (sts_i.stop) begin
          cmd_o.occ_inc = 1'b1;
          res_d         = RES_OK;
          state_d       = S_RESP;
        end else begin
          // shift the smaller entry one place toward the tail
          cmd_o.wr_sel  = WR_RDATA;
          cmd_o.idx_dec = 1'b1;
          state_d       = S_INS_RD;
        end
      end

      S_FRONT: begin
        if (sts_i.out_free) begin
          cmd_o.out_load = 1'b1;
          cmd_o.out_kind = RES_TAG;
          cmd_o.pop      = pop_q;
          state_d        = S_IDLE;
        end
      end

      S_RESP: begin
        if (sts_i.out_free) begin
          cmd_o.out_load = 1'b1;
          cmd_o.out_kind = res_q;
          state_d        = S_IDLE;
        end
      end

      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

endmodule

`default_nettype wire

### rtl/pqsl_dpath.sv
// Datapath for the sorted-list priority queue: entry memory, pointers, result register.
`timescale 1ns / 1ps
`default_nettype none

module pqsl_dpath
  import pqsl_pkg::*;
#(
  parameter int unsigned DEPTH = 16
) (
  input  wire logic                     clk_i,
  input  wire logic                     rst_ni,
  input  wire logic signed [PRIO_W-1:0] priority_req_i,
  input  wire logic        [TAG_W-1:0]  tag_i,
  input  wire cmd_t                     cmd_i,
  output sts_t                          sts_o,
  output logic                          res_valid_o,
  input  wire logic                     res_stall_i,
  output logic             [TAG_W-1:0]  out_tag_o,
  output logic                          out_valid_o,
  output logic             [1:0]        status_o
);

  localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CW = $clog2(DEPTH + 1);
  localparam logic [AW:0]   DEPTH_A = (AW + 1)'(DEPTH);
  localparam logic [CW-1:0] DEPTH_C = CW'(DEPTH);

  logic [WORD_W-1:0] mem [DEPTH];
  logic [WORD_W-1:0] rdata_q;

  logic [AW-1:0]            head_q;
  logic [CW-1:0]            occ_q;
  logic [CW-1:0]            idx_q;
  logic signed [PRIO_W-1:0] prio_q;
  logic [TAG_W-1:0]         tag_q;

  logic             res_valid_q;
  logic [TAG_W-1:0] out_tag_q;
  logic             out_valid_q;
  logic [1:0]       status_q;

  logic [AW-1:0]     idx_a, idx_m1_a, raddr, waddr;
  logic [WORD_W-1:0] wdata;
  logic              out_free;

  // Map a queue position to a memory row, wrapping around the ring
  function automatic logic [AW-1:0] phys(input logic [AW-1:0] head,
                                         input logic [AW-1:0] pos);
    logic [AW:0] sum;
    sum = {1'b0, head} + {1'b0, pos};
    if (sum >= DEPTH_A) begin
      sum = sum - DEPTH_A;
    end
    return sum[AW-1:0];
  endfunction

  assign idx_a    = idx_q[AW-1:0];
  assign idx_m1_a = idx_a - AW'(1);
  assign raddr    = (cmd_i.rd_sel == RD_IDX_M1) ? phys(head_q, idx_m1_a) : head_q;
  assign waddr    = phys(head_q, idx_a);
  assign wdata    = (cmd_i.wr_sel == WR_RDATA) ? rdata_q : {prio_q, tag_q};
  assign out_free = !res_valid_q || !res_stall_i;

  always_ff @(posedge clk_i) begin
    if (cmd_i.wr_en) begin
      mem[waddr] <= wdata;
    end
    rdata_q <= mem[raddr];
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.capture) begin
      prio_q <= priority_req_i;
      tag_q  <= tag_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      head_q <= '0;
      occ_q  <= '0;
      idx_q  <= '0;
    end else begin
      if (cmd_i.capture) begin
        idx_q <= occ_q;
      end else if (cmd_i.idx_dec) begin
        idx_q <= idx_q - CW'(1);
      end
      if (cmd_i.occ_inc) begin
        occ_q <= occ_q + CW'(1);
      end else if (cmd_i.pop) begin
        occ_q  <= occ_q - CW'(1);
        head_q <= ({1'b0, head_q} + (AW + 1)'(1) == DEPTH_A) ? '0 : head_q + AW'(1);
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      res_valid_q <= 1'b0;
    end else if (cmd_i.out_load) begin
      res_valid_q <= 1'b1;
    end else if (!res_stall_i) begin
      res_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.out_load) begin
      case (cmd_i.out_kind)
        RES_TAG: begin
          out_tag_q   <= rdata_q[TAG_W-1:0];
          out_valid_q <= 1'b1;
          status_q    <= STATUS_OK;
        end
        RES_EMPTY: begin
          out_tag_q   <= '0;
          out_valid_q <= 1'b0;
          status_q    <= STATUS_EMPTY;
        end
        RES_FULL: begin
          out_tag_q   <= '0;
          out_valid_q <= 1'b0;
          status_q    <= STATUS_FULL;
        end
        default: begin
          out_tag_q   <= '0;
          out_valid_q <= 1'b0;
          status_q    <= STATUS_OK;
        end
      endcase
    end
  end

  assign sts_o.occ_zero = (occ_q == '0);
  assign sts_o.occ_full = (occ_q == DEPTH_C);
  assign sts_o.idx_zero = (idx_q == '0);
  assign sts_o.stop     = ($signed(rdata_q[WORD_W-1:TAG_W]) >= prio_q);
  assign sts_o.out_free = out_free;

  assign res_valid_o = res_valid_q;
  assign out_tag_o   = out_tag_q;
  assign out_valid_o = out_valid_q;
  assign status_o    = status_q;

endmodule

`default_nettype wire

### rtl/priority_queue_sorted_list_unit.sv
// Top level of the sorted-list priority queue: controller plus datapath.
//
// Usage: one request per accepted handshake on the req channel (req_valid_i
// high, req_stall_o low). func_i selects insert, remove-highest or peek-highest;
// priority_req_i and tag_i matter only for insert. Every request yields exactly
// one response on the res channel (res_valid_o high, res_stall_i low) with
// out_tag_o, out_valid_o and status_o.
// Entries live in a ring-addressed memory, largest priority at the head, equal
// priorities in arrival order. Remove advances the head pointer in place.
// Insert walks from the tail toward the head, reading and then writing each
// position passed, shifting smaller entries back one slot.
// Because the memory read is registered, each position takes a read state
// (S_INS_RD) and then a compare-and-write state (S_INS_CMP).
// The block takes the next request as soon as the controller is idle, even if
// the previous response still waits under res_stall_i; a finished response
// then holds in its state until the output register frees up.
// Reset empties the queue at once (occupancy and head cleared); memory
// contents are left as they are and are never used before being written.
`timescale 1ns / 1ps
`default_nettype none

module priority_queue_sorted_list_unit
  import pqsl_pkg::*;
#(
  parameter int unsigned DEPTH = 16
) (
  input  wire logic                     clk_i,
  input  wire logic                     rst_ni,
  // request channel
  input  wire logic                     req_valid_i,
  output logic                          req_stall_o,
  input  wire logic        [1:0]        func_i,
  input  wire logic signed [PRIO_W-1:0] priority_req_i,
  input  wire logic        [TAG_W-1:0]  tag_i,
  // response channel
  output logic                          res_valid_o,
  input  wire logic                     res_stall_i,
  output logic             [TAG_W-1:0]  out_tag_o,
  output logic                          out_valid_o,
  output logic             [1:0]        status_o
);

  cmd_t cmd;
  sts_t sts;

  // Sequence each request: decode, tail-to-head insert walk, response hand-off
  pqsl_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .req_valid_i (req_valid_i),
    .req_stall_o (req_stall_o),
    .func_i      (func_i),
    .sts_i       (sts),
    .cmd_o       (cmd)
  );

  // Hold the entries, head/occupancy pointers and the response register
  pqsl_dpath #(
    .DEPTH (DEPTH)
  ) u_dpath (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .priority_req_i (priority_req_i),
    .tag_i          (tag_i),
    .cmd_i          (cmd),
    .sts_o          (sts),
    .res_valid_o    (res_valid_o),
    .res_stall_i    (res_stall_i),
    .out_tag_o      (out_tag_o),
    .out_valid_o    (out_valid_o),
    .status_o       (status_o)
  );

endmodule

`default_nettype wire
